// ===== hw/rtl/wmf_pkg.sv =====
// Package for the window median filter.
// Holds the register reset value and the control and link types shared by the cell chain.
// No dependencies.
`default_nettype none

package wmf_pkg;

  // Width of the window count register and its value after reset.
  localparam int unsigned CountWidth = 8;
  localparam logic [CountWidth-1:0] COUNT_RESET = 8'd75;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic take;   // a sample transfer happens at this edge
    logic clear;  // the window ends or is discarded at this edge
  } wmf_ctrl_t;

  // Status handed from one cell to its right-hand neighbor.
  typedef struct packed {
    logic valid;  // the cell holds a sample of the current window
    logic open;   // the incoming sample sorts before the cell's value, or the cell is empty
  } wmf_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/window_median_filter.sv =====
// Window median filter: a window's median stands valid on the output in the cycle after
// the transfer of its last sample; one sample is taken in every cycle unless the input stalls.
// Each sample is inserted into a chain of MAX_WINDOW sorting cells.
// The input stalls only while a finished median waits and the output is not ready.
// Reset empties the window and sets the window count to 75.
// Throughput: one sample per cycle unless stalled, one result per window_count samples.
`default_nettype none

module window_median_filter #(
  parameter int unsigned MAX_WINDOW   = 128,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Sample channel.
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      median_o,
  // Configuration channel carrying the window count.
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wmf_pkg::CountWidth-1:0] window_count_i
);
  import wmf_pkg::*;

  // CntW holds a fill count up to MAX_WINDOW; IdxW addresses one cell.
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CountWidth-1:0]          window_count_q;
  logic [CntW-1:0]                fill_q;
  logic [CntW-1:0]                fill_d;
  logic                           out_valid_q;
  logic                           out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] median_q;

  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] mid;
  logic [IdxW-1:0] mid_idx;
  logic            in_xfer;
  logic            cfg_xfer;
  logic            last;
  wmf_ctrl_t       ctrl;

  wmf_link_t                      link      [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] value     [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] next_value[MAX_WINDOW];

  // The window count in use: zero acts as one, and counts above the chain
  // length saturate to the chain length.
  always_comb begin
    if (window_count_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(window_count_q) > MAX_WINDOW) begin
      n_eff = CntW'(MAX_WINDOW);
    end else begin
      n_eff = CntW'(window_count_q);
    end
  end

  // The result is the element at rank n/2, counted from zero.
  assign mid     = n_eff >> 1;
  assign mid_idx = mid[IdxW-1:0];

  // A new sample is taken if the output register is free or is emptied at the same edge.
  // Configuration writes must arrive only while idle; the block does not enforce this.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // The sample being transferred completes the window.
  assign last = ({1'b0, fill_q} + {{CntW{1'b0}}, 1'b1}) >= {1'b0, n_eff};

  // A completed window or a new window count empties the chain.
  assign ctrl.take  = in_xfer;
  assign ctrl.clear = cfg_xfer || (in_xfer && last);

  // Sorting chain: cell 0 holds the smallest sample. Every cell sees the
  // incoming sample and its left neighbor, so all cells update in parallel.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    wmf_link_t                      left;
    logic signed [SAMPLE_WIDTH-1:0] left_value;

    if (i == 0) begin : g_head
      // Nothing to the left: the head never shifts in; a take without a clear leaves it valid.
      assign left.valid = 1'b1;
      assign left.open  = 1'b0;
      assign left_value = sample_i;
    end else begin : g_body
      assign left       = link[i-1];
      assign left_value = value[i-1];
    end

    wmf_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sample_i    (sample_i),
      .left_i      (left),
      .left_value_i(left_value),
      .link_o      (link[i]),
      .value_o     (value[i]),
      .next_value_o(next_value[i])
    );
  end

  // Window fill count: cleared at the end of a window and on a new count.
  always_comb begin
    fill_d = fill_q;
    if (ctrl.clear) begin
      fill_d = '0;
    end else if (in_xfer) begin
      fill_d = fill_q + CntW'(1);
    end
  end

  // Output register: the median is picked from the chain's next contents,
  // so the result is ready right after the last sample's transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer && last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q <= COUNT_RESET;
      fill_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        window_count_q <= window_count_i;
      end
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last) begin
      median_q <= next_value[mid_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wmf_cell.sv =====
// One cell of the sorting chain of the window median filter.
// Holds one sample of the ascending window and shifts right when a smaller sample is inserted.
// Depends on wmf_pkg.
`default_nettype none

module wmf_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire wmf_pkg::wmf_ctrl_t        ctrl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire wmf_pkg::wmf_link_t        left_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_value_i,
  output wmf_pkg::wmf_link_t             link_o,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic signed [SAMPLE_WIDTH-1:0] next_value_o
);
  import wmf_pkg::*;

  logic                           valid_q;
  logic                           valid_d;
  logic signed [SAMPLE_WIDTH-1:0] value_q;
  logic                           open;

  // An empty cell counts as holding the largest value.
  assign open = !valid_q || (sample_i < value_q);

  // An open cell takes the left neighbor's value if that one shifts too,
  // otherwise the new sample lands here.
  always_comb begin
    if (!open) begin
      next_value_o = value_q;
    end else if (left_i.open) begin
      next_value_o = left_value_i;
    end else begin
      next_value_o = sample_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.take) begin
      valid_d = left_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      value_q <= next_value_o;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.open  = open;
  assign value_o      = value_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for window_median_filter: random and directed sample streams under several
// window counts, with every median checked against a scoreboard that ranks each window.
// Depends on wmf_pkg and the window_median_filter RTL.
`timescale 1ns / 100ps

module tb;
  import wmf_pkg::*;

  localparam int unsigned MaxWindow    = 128;
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned SampleTarget = 1750;
  // This limit lies far above any correct run, so it only catches hangs.
  localparam int unsigned CycleLimit   = 400000;
  // The median is valid in the cycle after the last sample; the settle wait adds margin.
  localparam int unsigned SettleCycles = 4;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [CountWidth-1:0] count_t;

  // The scoreboard keeps its own copy of the window and of the window count. Each accepted
  // sample joins the window, and once the window is full its middle-ranked value is queued
  // as the next median the block must deliver.
  class median_scoreboard;
    sample_t     window_q[$];
    sample_t     medians_q[$];
    count_t      count_reg;
    int unsigned errors;
    int unsigned medians_checked;

    function new();
      count_reg       = COUNT_RESET;
      errors          = 0;
      medians_checked = 0;
    endfunction

    // A zero count acts as one and counts beyond the store saturate.
    function int unsigned span();
      if (count_reg == '0) begin
        return 1;
      end
      if (32'(count_reg) > MaxWindow) begin
        return MaxWindow;
      end
      return 32'(count_reg);
    endfunction

    // A new count throws away whatever part of a window was collected.
    function void set_count(count_t value);
      count_reg = value;
      window_q.delete();
    endfunction

    function int unsigned pending();
      return medians_q.size();
    endfunction

    // Picks the value whose rank is size/2: it is the one with no more than that many
    // smaller values, while those plus its equals reach past that rank.
    function sample_t middle_rank();
      int unsigned target;
      sample_t     found;
      target = window_q.size() / 2;
      found  = '0;
      foreach (window_q[i]) begin
        int unsigned below;
        int unsigned same;
        below = 0;
        same  = 0;
        foreach (window_q[j]) begin
          if (window_q[j] < window_q[i]) begin
            below++;
          end else if (window_q[j] == window_q[i]) begin
            same++;
          end
        end
        if (target >= below && target < below + same) begin
          found = window_q[i];
        end
      end
      return found;
    endfunction

    function void note_sample(sample_t value);
      window_q.push_back(value);
      if (window_q.size() >= span()) begin
        medians_q.push_back(middle_rank());
        window_q.delete();
      end
    endfunction

    function void check_median(sample_t actual);
      sample_t wanted;
      if (medians_q.size() == 0) begin
        $display("%0t: median with none expected, expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      wanted = medians_q.pop_front();
      medians_checked++;
      if (actual !== wanted) begin
        $display("%0t: median mismatch, expected %0d, actual %0d", $time, wanted, actual);
        errors++;
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    in_valid_i     = 1'b0;
  sample_t sample_i       = '0;
  logic    out_ready_i    = 1'b0;
  logic    cfg_valid_i    = 1'b0;
  count_t  window_count_i = '0;

  logic    in_ready_o;
  logic    out_valid_o;
  sample_t median_o;
  logic    cfg_ready_o;

  median_scoreboard sb = new();

  // Idle rates in percent, changed from phase to phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycles         = 0;
  int unsigned samples_sent   = 0;
  int unsigned settings_used  = 0;
  sample_t     ramp_val       = '0;

  window_median_filter #(
    .MAX_WINDOW  (MaxWindow),
    .SAMPLE_WIDTH(SampleWidth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .median_o      (median_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .window_count_i(window_count_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The result side stalls at random, at the rate that the current phase sets.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every median transfer is checked against the oldest expected value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_median(median_o);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Idle modes cycle through: none, sender only, receiver only, and both at a lower rate.
  task automatic set_mode(input int unsigned mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 54;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 54;
      end
      default: begin
        send_idle_pct  = 34;
        recv_stall_pct = 34;
      end
    endcase
  endtask

  // Offers one sample after an optional random gap and holds it until the transfer. Valid is
  // lowered only on an idle cycle, so back-to-back samples keep it high without a glitch.
  task automatic push_sample(input sample_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(value);
    samples_sent++;
  endtask

  // The count is written only with the block idle: all medians delivered, then a short pause
  // so that nothing from a partial window is still in flight.
  task automatic write_count(input count_t value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    window_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_count(value);
    settings_used++;
  endtask

  // Sample patterns: full-range noise, a narrow band full of duplicates, the extremes,
  // and a slow ramp that arrives already sorted.
  function automatic sample_t next_sample(input int unsigned style);
    case (style)
      2: return sample_t'(int'($urandom_range(0, 6)) - 3);
      3: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      4: begin
        ramp_val = ramp_val + sample_t'(37);
        return ramp_val;
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sends a number of samples, picking a new pattern at the start of every window.
  task automatic stream_samples(input int unsigned total);
    int unsigned style;
    style = 0;
    for (int unsigned i = 0; i < total; i++) begin
      if (i % sb.span() == 0) begin
        style = $urandom_range(0, 4);
      end
      push_sample(next_sample(style));
    end
  endtask

  initial begin
    count_t      fixed_counts[9];
    count_t      count;
    int unsigned phase;
    int unsigned windows;
    int unsigned total;

    fixed_counts = '{8'd1, 8'd128, 8'd255, 8'd129, 8'd2, 8'd7, 8'd75, 8'd16, 8'd3};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two full windows at the count that reset leaves behind.
    set_mode(0);
    stream_samples(150);

    // A zero count acts as one, so each extreme comes straight back as its own median.
    write_count(8'd0);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh0000);
    push_sample(16'shffff);

    // Both extremes in one odd window leave the zero in the middle.
    write_count(8'd3);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh0000);

    // Even windows deliver the upper of the two middle values.
    write_count(8'd2);
    push_sample(16'sd5);
    push_sample(-16'sd5);
    write_count(8'd4);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(-16'sd1);
    push_sample(16'sd1);

    // A count write in the middle of a window drops the samples gathered so far.
    write_count(8'd3);
    push_sample(16'sd100);
    push_sample(16'sd200);
    write_count(8'd1);
    push_sample(-16'sd7);

    // Random phases: the fixed list covers the corners, then mostly small windows so that
    // medians stay frequent. Some phases end on a partial window that the next write drops.
    phase = 0;
    while (samples_sent < SampleTarget) begin
      if (phase < 9) begin
        count = fixed_counts[phase];
      end else begin
        case ($urandom_range(0, 9))
          0:       count = count_t'($urandom_range(0, 255));
          1, 2:    count = count_t'($urandom_range(13, 40));
          default: count = count_t'($urandom_range(1, 12));
        endcase
      end
      write_count(count);
      set_mode(phase);
      windows = (sb.span() > 40) ? $urandom_range(1, 2) : $urandom_range(2, 8);
      total   = sb.span() * windows;
      if ($urandom_range(0, 3) == 0) begin
        total += $urandom_range(0, sb.span() - 1);
      end
      stream_samples(total);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("tb: %0d samples sent, %0d medians checked, %0d window count writes",
             samples_sent, sb.medians_checked, settings_used);
    $display("tb: windows from 1 to 128 samples, counts 0 and above 128 included");
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
